### sv/framebuffer_shape_rasterizer_core_defines.svh
// Assertion macros for the shape rasterizer core.
// Depends on nothing; included by the top level, which supplies clk and rst.
`ifndef FRAMEBUFFER_SHAPE_RASTERIZER_CORE_DEFINES_SVH
`define FRAMEBUFFER_SHAPE_RASTERIZER_CORE_DEFINES_SVH

// Checks that a condition holds in every cycle outside reset.
`define FSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define FSR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### sv/fsr_pkg.sv
// Package of the shape rasterizer: command and result beat types, mode codes
// and default frame size. Depends on nothing.
package fsr_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 128;

  // Internal coordinate and decision widths.
  localparam int CW = 14;
  localparam int DW = 16;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_PIXEL  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_RECT   = 3'd3;
  localparam logic [2:0] MODE_CIRCLE = 3'd4;
  localparam logic [2:0] MODE_DISC   = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [15:0] color;
    logic signed [11:0] x0;
    logic signed [11:0] y0;
    logic signed [11:0] x1;
    logic signed [11:0] y1;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic        [9:0]  radius;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_color;
    logic        read_valid;
  } res_t;

endpackage

### sv/framebuffer_shape_rasterizer_core.sv
// Top level of the shape rasterizer: command sequencer and frame memory.
// Depends on fsr_pkg and framebuffer_shape_rasterizer_core_defines.svh.
//
//  Channel   Signals                 Handshake
//  --------  ----------------------  ------------------------------------------
//  command   start, busy, cmd        beat taken at an edge with start & !busy
//  result    done, result            one beat per command, done high one cycle
//
// Every command gives one result beat: a pixel set, a read, an unused mode, a line, a rectangle
// (clipped) or a circle. A line and each span of a filled circle draw one pixel after another.
// A circle outline plots eight points per midpoint step, a filled circle draws spans per step;
// the single memory write port draws at most one pixel per cycle.
// A clear sweeps all FRAME_WIDTH*FRAME_HEIGHT words; after reset the same sweep runs
// with busy high. The receiver cannot stall.
`include "framebuffer_shape_rasterizer_core_defines.svh"

module framebuffer_shape_rasterizer_core #(
  parameter int FRAME_WIDTH  = fsr_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = fsr_pkg::FRAME_HEIGHT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fsr_pkg::cmd_t cmd,
  output logic          done,
  output fsr_pkg::res_t result
);

  localparam int CW    = fsr_pkg::CW;
  localparam int DW    = fsr_pkg::DW;
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);

  localparam logic signed [CW-1:0] FW_C = CW'(FRAME_WIDTH);
  localparam logic signed [CW-1:0] FH_C = CW'(FRAME_HEIGHT);
  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] ZERO = '0;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_PUT1  = 4'd2;
  localparam logic [3:0] S_LSET  = 4'd3;
  localparam logic [3:0] S_BRES  = 4'd4;
  localparam logic [3:0] S_SPAN  = 4'd5;
  localparam logic [3:0] S_RSET  = 4'd6;
  localparam logic [3:0] S_RECT  = 4'd7;
  localparam logic [3:0] S_PLOT8 = 4'd8;
  localparam logic [3:0] S_CSTEP = 4'd9;
  localparam logic [3:0] S_FSET  = 4'd10;
  localparam logic [3:0] S_READ  = 4'd11;
  localparam logic [3:0] S_RFIN  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state;
  logic [AW-1:0] clr_cnt;
  logic clr_cmd;

  // Command fields held for the length of the command.
  logic [15:0] color;
  logic signed [CW-1:0] cx, cy, rw, rh;
  logic fill, ret_circ, first;

  // Circle walk: offsets a, b, decision d, sub-step k.
  logic signed [CW-1:0] ca, cb;
  logic signed [DW-1:0] cd;
  logic [2:0] k;

  // Line endpoints, Bresenham state and span state.
  logic signed [CW-1:0] lax, lay, lbx, lby;
  logic signed [CW-1:0] ldx, ldy, err;
  logic lsx, lsy;
  logic signed [CW-1:0] span_x, span_hi;

  // Rectangle sweep.
  logic signed [CW-1:0] ri, rj, ryl, rxl_last, ryl_last;

  logic [15:0] rd_q;
  logic rd_ok;

  // Frame memory: one write port, one registered read port.
  logic [15:0] mem [DEPTH];

  logic signed [CW-1:0] px, py, xr;
  logic pen, in_frame, we;
  logic [AW-1:0] addr, waddr;
  logic [15:0] wdata;

  function automatic logic signed [CW-1:0] pos(input logic signed [CW-1:0] v);
    return (v > ZERO) ? v : ZERO;
  endfunction

  assign busy = (state != S_IDLE);

  // The pixel that the current state would draw.
  always_comb begin
    px  = cx;
    py  = cy;
    pen = 1'b0;
    case (state)
      S_PUT1: begin
        pen = 1'b1;
      end
      S_BRES: begin
        px  = lax;
        py  = lay;
        pen = 1'b1;
      end
      S_SPAN: begin
        px  = span_x;
        py  = lay;
        pen = 1'b1;
      end
      S_RECT: begin
        px  = ri;
        py  = rj;
        pen = 1'b1;
      end
      S_PLOT8: begin
        pen = 1'b1;
        case (k)
          3'd0: begin px = cx + ca; py = cy + cb; end
          3'd1: begin px = cx - ca; py = cy + cb; end
          3'd2: begin px = cx + ca; py = cy - cb; end
          3'd3: begin px = cx - ca; py = cy - cb; end
          3'd4: begin px = cx + cb; py = cy + ca; end
          3'd5: begin px = cx - cb; py = cy + ca; end
          3'd6: begin px = cx + cb; py = cy - ca; end
          default: begin px = cx - cb; py = cy - ca; end
        endcase
      end
      default: begin
        pen = 1'b0;
      end
    endcase
  end

  // Rotated layout: column (FRAME_WIDTH - x - 1) holds FRAME_HEIGHT pixels.
  always_comb begin
    in_frame = (px >= ZERO) && (px < FW_C) && (py >= ZERO) && (py < FH_C);
    xr       = (FW_C - ONE) - px;
    addr     = AW'(xr[XW-1:0]) * AW'(FRAME_HEIGHT) + AW'(py[YW-1:0]);
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else begin
      we    = pen && in_frame;
      waddr = addr;
      wdata = color;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[addr];
  end

  // Line setup values after endpoint clamping.
  logic signed [CW-1:0] cax, cay, cbx, cby, lo, hi;
  always_comb begin
    cax = (lax >= FW_C) ? FW_C - ONE : lax;
    cbx = (lbx >= FW_C) ? FW_C - ONE : lbx;
    cay = (lay >= FH_C) ? FH_C - ONE : lay;
    cby = (lby >= FH_C) ? FH_C - ONE : lby;
    lo  = (cax < cbx) ? cax : cbx;
    hi  = (cax < cbx) ? cbx : cax;
    if (lo < ZERO) begin
      lo = ZERO;
    end
  end

  // Bresenham step.
  logic signed [CW-1:0] e2;
  logic step_x, step_y;
  always_comb begin
    e2     = err <<< 1;
    step_x = (e2 >= ldy);
    step_y = (e2 <= ldx);
  end

  // Rectangle bounds.
  logic signed [CW-1:0] rxl, ryl_c, rxh, ryh;
  always_comb begin
    rxl   = pos(cx);
    ryl_c = pos(cy);
    rxh   = ((cx + rw) < FW_C) ? cx + rw : FW_C;
    ryh   = ((cy + rh) < FH_C) ? cy + rh : FH_C;
  end

  // Span endpoints of a filled circle.
  logic signed [CW-1:0] sp_l, sp_r, sp_y, sp_off;
  always_comb begin
    sp_off = (k < 3'd2) ? ca : cb;
    sp_l   = cx - sp_off;
    sp_r   = cx + sp_off;
    case (k)
      3'd0:    sp_y = cy - cb;
      3'd1:    sp_y = cy + cb;
      3'd2:    sp_y = cy - ca;
      default: sp_y = cy + ca;
    endcase
    if (first) begin
      sp_l = pos(sp_l);
      if (!k[0]) begin
        sp_y = pos(sp_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      clr_cmd <= 1'b0;
      done    <= 1'b0;
      result  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            color    <= cmd.color;
            cx       <= CW'(cmd.x0);
            cy       <= CW'(cmd.y0);
            rw       <= CW'(cmd.rect_width);
            rh       <= CW'(cmd.rect_height);
            lax      <= CW'(cmd.x0);
            lay      <= CW'(cmd.y0);
            lbx      <= CW'(cmd.x1);
            lby      <= CW'(cmd.y1);
            ret_circ <= 1'b0;
            fill     <= (cmd.mode == fsr_pkg::MODE_DISC);
            ca       <= '0;
            cb       <= CW'(cmd.radius);
            cd       <= DW'(3) - (DW'(cmd.radius) << 1);
            k        <= '0;
            first    <= 1'b1;
            case (cmd.mode)
              fsr_pkg::MODE_CLEAR: begin
                clr_cnt <= '0;
                clr_cmd <= 1'b1;
                state   <= S_CLEAR;
              end
              fsr_pkg::MODE_PIXEL: state <= S_PUT1;
              fsr_pkg::MODE_LINE:  state <= S_LSET;
              fsr_pkg::MODE_RECT:  state <= S_RSET;
              fsr_pkg::MODE_CIRCLE: begin
                state <= (cmd.radius == '0) ? S_PUT1 : S_PLOT8;
              end
              fsr_pkg::MODE_DISC: begin
                state <= (cmd.radius == '0) ? S_PUT1 : S_FSET;
              end
              fsr_pkg::MODE_READ: state <= S_READ;
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state   <= S_IDLE;
            done    <= clr_cmd;
            result  <= '0;
            clr_cmd <= 1'b0;
          end
        end
        S_PUT1, S_FIN: begin
          state  <= S_IDLE;
          done   <= 1'b1;
          result <= '0;
        end
        S_LSET: begin
          if (cay == cby) begin
            if (cay < ZERO || lo > hi) begin
              if (ret_circ) begin
                k     <= k + 3'd1;
                state <= S_FSET;
              end else begin
                state <= S_FIN;
              end
            end else begin
              lay     <= cay;
              span_x  <= lo;
              span_hi <= hi;
              state   <= S_SPAN;
            end
          end else begin
            lax   <= cax;
            lay   <= cay;
            lbx   <= cbx;
            lby   <= cby;
            ldx   <= (cbx > cax) ? cbx - cax : cax - cbx;
            ldy   <= (cby > cay) ? cay - cby : cby - cay;
            lsx   <= !(cax < cbx);
            lsy   <= !(cay < cby);
            err   <= ((cbx > cax) ? cbx - cax : cax - cbx)
                   + ((cby > cay) ? cay - cby : cby - cay);
            state <= S_BRES;
          end
        end
        S_BRES: begin
          if (lax == lbx && lay == lby) begin
            if (ret_circ) begin
              k     <= k + 3'd1;
              state <= S_FSET;
            end else begin
              state <= S_FIN;
            end
          end else begin
            err <= err + (step_x ? ldy : ZERO) + (step_y ? ldx : ZERO);
            if (step_x) begin
              lax <= lsx ? lax - ONE : lax + ONE;
            end
            if (step_y) begin
              lay <= lsy ? lay - ONE : lay + ONE;
            end
          end
        end
        S_SPAN: begin
          if (span_x == span_hi) begin
            if (ret_circ) begin
              k     <= k + 3'd1;
              state <= S_FSET;
            end else begin
              state <= S_FIN;
            end
          end else begin
            span_x <= span_x + ONE;
          end
        end
        S_RSET: begin
          if (rw <= ZERO || rh <= ZERO || rxl >= rxh || ryl_c >= ryh) begin
            state <= S_FIN;
          end else begin
            ri       <= rxl;
            rj       <= ryl_c;
            ryl      <= ryl_c;
            rxl_last <= rxh - ONE;
            ryl_last <= ryh - ONE;
            state    <= S_RECT;
          end
        end
        S_RECT: begin
          if (rj == ryl_last) begin
            rj <= ryl;
            if (ri == rxl_last) begin
              state <= S_FIN;
            end else begin
              ri <= ri + ONE;
            end
          end else begin
            rj <= rj + ONE;
          end
        end
        S_PLOT8: begin
          k <= k + 3'd1;
          if (k == 3'd7) begin
            state <= S_CSTEP;
          end
        end
        S_FSET: begin
          if (k == 3'd4) begin
            first <= 1'b0;
            state <= S_CSTEP;
          end else begin
            lax      <= sp_l;
            lbx      <= sp_r;
            lay      <= sp_y;
            lby      <= sp_y;
            ret_circ <= 1'b1;
            state    <= S_LSET;
          end
        end
        S_CSTEP: begin
          if (cb >= ca) begin
            ca <= ca + ONE;
            k  <= '0;
            if (cd > DW'(0)) begin
              cb <= cb - ONE;
              cd <= cd + (DW'(ca - cb) <<< 2) + DW'(18);
            end else begin
              cd <= cd + (DW'(ca) <<< 2) + DW'(10);
            end
            state <= fill ? S_FSET : S_PLOT8;
          end else begin
            state <= S_FIN;
          end
        end
        S_READ: begin
          rd_ok <= in_frame;
          state <= S_RFIN;
        end
        S_RFIN: begin
          state             <= S_IDLE;
          done              <= 1'b1;
          result.read_color <= rd_ok ? rd_q : 16'd0;
          result.read_valid <= rd_ok;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat only appears as the block returns to idle.
  `FSR_ASSERT_ALWAYS(a_done_idle, !(done && busy), "result beat while busy")
  // An accepted command makes the block busy in the cycle after it is taken.
  `FSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command not started")
  // The strobe lasts a single cycle.
  `FSR_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  // Nothing is written to the frame while idle.
  `FSR_ASSERT_ALWAYS(a_idle_no_write, busy || !we, "frame write while idle")

endmodule
